@@ hw/rtl/cst_pkg.sv @@
package cst_pkg;

    localparam int ANG_W      = 17;
    localparam int POS_W      = 18;
    localparam int MAG_W      = 18;
    localparam int DUR_W      = 20;
    localparam int ELAP_W     = 21;
    localparam int OFS_W      = 16;
    localparam int STEP_W     = 10;
    localparam int SPD_W      = 16;
    localparam int MTIME_W    = 16;
    localparam int CMD_W      = 18;
    localparam int K_MS_W     = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam logic [K_MS_W-1:0] K_MS    = 10'd1000;
    localparam logic [DUR_W-1:0]  DUR_MAX = 20'hFFFFF;

    localparam logic signed [ANG_W-1:0] MIN_ANGLE_RST = -17'sd17920;
    localparam logic signed [ANG_W-1:0] MAX_ANGLE_RST = 17'sd17920;
    localparam logic [OFS_W-1:0]        OFFSET_RST    = 16'd23040;
    localparam logic [STEP_W-1:0]       STEP_RST      = 10'd40;
    localparam logic                    MODE_RST      = 1'b1;
    localparam logic [SPD_W-1:0]        SPEED_RST     = 16'd0;
    localparam logic [MTIME_W-1:0]      MTIME_RST     = 16'd1000;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_ANGLE    = 3'd0,
        REG_MAX_ANGLE    = 3'd1,
        REG_OFFSET_ANGLE = 3'd2,
        REG_STEP_MS      = 3'd3,
        REG_MOVE_MODE    = 3'd4,
        REG_SPEED_UNITS  = 3'd5,
        REG_MOVE_TIME_MS = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_MAG_K = 2'd0,
        MUL_SS    = 2'd1,
        MUL_S2S   = 2'd2,
        MUL_MAGH  = 2'd3
    } mul_sel_t;

    typedef enum logic {
        DIV_SPEED = 1'b0,
        DIV_TIME  = 1'b1
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     set_latch;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     dur_load;
        logic     tick_eval;
        logic     s_load;
        logic     s2_load;
        logic     h_load;
        logic     ang_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic need_speed_div;
        logic move_cond;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/cst_div.sv @@
module cst_div #(
    parameter int NW  = 36,
    parameter int DVW = 20
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [NW-1:0]  quotient
);

    localparam int CNT_W = $clog2(NW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVW-1:0]   rem_reg;
    logic [DVW-1:0]   dsr_reg;
    logic [NW-1:0]    quo_reg;

    logic [DVW:0]     rem_sh;
    logic [DVW:0]     rem_sub;
    logic             ge;
    logic [DVW-1:0]   rem_next;
    logic [NW-1:0]    quo_next;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[NW-1]};
        rem_sub  = rem_sh - {1'b0, dsr_reg};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_next = ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        quo_next = {quo_reg[NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/cst_dp.sv @@
module cst_dp #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cst_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cst_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [cst_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cst_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  cst_pkg::cmd_t                     cmd,
    output cst_pkg::sts_t                     sts
);

    localparam int SW    = FRACTION_BITS + 1;
    localparam int OPW   = (SW > cst_pkg::MAG_W) ? SW : cst_pkg::MAG_W;
    localparam int PW    = 2 * OPW;
    localparam int DW    = cst_pkg::DUR_W + FRACTION_BITS;
    localparam int HW    = SW + 2;
    localparam int KP_W  = cst_pkg::MAG_W + cst_pkg::K_MS_W;
    localparam int PAD_W = cst_pkg::OUT_TDATA_W - cst_pkg::CMD_W - 1 - cst_pkg::ANG_W;

    localparam logic [SW-1:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [PW-1:0] HALF = PW'(ONE >> 1);

    logic signed [cst_pkg::ANG_W-1:0]   min_angle_reg;
    logic signed [cst_pkg::ANG_W-1:0]   max_angle_reg;
    logic [cst_pkg::OFS_W-1:0]          offset_reg;
    logic [cst_pkg::STEP_W-1:0]         step_reg;
    logic                               mode_reg;
    logic [cst_pkg::SPD_W-1:0]          speed_reg;
    logic [cst_pkg::MTIME_W-1:0]        mtime_reg;

    logic [cst_pkg::POS_W-1:0]          cur_reg;
    logic [cst_pkg::POS_W-1:0]          start_reg;
    logic [cst_pkg::POS_W-1:0]          target_reg;
    logic [cst_pkg::ELAP_W-1:0]         elapsed_reg;
    logic [cst_pkg::DUR_W-1:0]          dur_reg;
    logic                               busy_reg;
    logic                               m_valid_reg;

    logic signed [cst_pkg::ANG_W-1:0]   in_target_reg;
    logic [SW-1:0]                      s_reg;
    logic [SW-1:0]                      s2_reg;
    logic [SW-1:0]                      h_reg;
    logic [PW-1:0]                      prod_reg;
    logic [cst_pkg::OUT_TDATA_W-1:0]    m_data_reg;

    logic signed [cst_pkg::ANG_W-1:0]   clamp_hi;
    logic signed [cst_pkg::ANG_W-1:0]   clamp_val;
    logic [cst_pkg::POS_W:0]            diff;
    logic [cst_pkg::POS_W:0]            diff_neg;
    logic [cst_pkg::MAG_W-1:0]          mag;
    logic [cst_pkg::DUR_W-1:0]          t_val;
    logic [DW-1:0]                      div_dividend;
    logic [cst_pkg::DUR_W-1:0]          div_divisor;
    logic                               div_done;
    logic [DW-1:0]                      quot;
    logic [cst_pkg::DUR_W-1:0]          dur_sat;
    logic [OPW-1:0]                     mul_a;
    logic [OPW-1:0]                     mul_b;
    logic [PW-1:0]                      prod_next;
    logic [SW-1:0]                      prod_hi;
    logic [HW-1:0]                      h_full;
    logic [SW-1:0]                      h_clamp;
    logic [PW-1:0]                      round_sum;
    logic [cst_pkg::MAG_W-1:0]          q_step;
    logic [cst_pkg::POS_W:0]            ang_sum;
    logic [cst_pkg::CMD_W-1:0]          servo_cmd;

    always_comb begin
        clamp_hi  = (in_target_reg > max_angle_reg) ? max_angle_reg : in_target_reg;
        clamp_val = (clamp_hi < min_angle_reg) ? min_angle_reg : clamp_hi;

        diff     = {target_reg[cst_pkg::POS_W-1], target_reg}
                 - {start_reg[cst_pkg::POS_W-1], start_reg};
        diff_neg = -diff;
        mag      = diff[cst_pkg::POS_W] ? diff_neg[cst_pkg::MAG_W-1:0]
                                        : diff[cst_pkg::MAG_W-1:0];

        t_val = (elapsed_reg > {1'b0, dur_reg}) ? dur_reg
                                                : elapsed_reg[cst_pkg::DUR_W-1:0];

        case (cmd.div_sel)
            cst_pkg::DIV_TIME: begin
                div_dividend = {t_val, {FRACTION_BITS{1'b0}}};
                div_divisor  = dur_reg;
            end
            default: begin
                div_dividend = DW'(prod_reg[KP_W-1:0]);
                div_divisor  = cst_pkg::DUR_W'(speed_reg);
            end
        endcase

        dur_sat = (|quot[DW-1:cst_pkg::DUR_W]) ? cst_pkg::DUR_MAX
                                               : quot[cst_pkg::DUR_W-1:0];

        prod_hi = prod_reg[FRACTION_BITS +: SW];

        case (cmd.mul_sel)
            cst_pkg::MUL_SS: begin
                mul_a = OPW'(s_reg);
                mul_b = OPW'(s_reg);
            end
            cst_pkg::MUL_S2S: begin
                mul_a = OPW'(prod_hi);
                mul_b = OPW'(s_reg);
            end
            cst_pkg::MUL_MAGH: begin
                mul_a = OPW'(mag);
                mul_b = OPW'(h_reg);
            end
            default: begin
                mul_a = OPW'(mag);
                mul_b = OPW'(cst_pkg::K_MS);
            end
        endcase
        prod_next = mul_a * mul_b;

        h_full  = {1'b0, s2_reg, 1'b0} + HW'(s2_reg) - {1'b0, prod_hi, 1'b0};
        h_clamp = (h_full > HW'(ONE)) ? ONE : h_full[SW-1:0];

        round_sum = prod_reg + HALF;
        q_step    = round_sum[FRACTION_BITS +: cst_pkg::MAG_W];
        ang_sum   = diff[cst_pkg::POS_W]
                  ? ({start_reg[cst_pkg::POS_W-1], start_reg} - {1'b0, q_step})
                  : ({start_reg[cst_pkg::POS_W-1], start_reg} + {1'b0, q_step});

        servo_cmd = cur_reg + cst_pkg::CMD_W'(offset_reg);
    end

    cst_div #(
        .NW  (DW),
        .DVW (cst_pkg::DUR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angle_reg <= cst_pkg::MIN_ANGLE_RST;
            max_angle_reg <= cst_pkg::MAX_ANGLE_RST;
            offset_reg    <= cst_pkg::OFFSET_RST;
            step_reg      <= cst_pkg::STEP_RST;
            mode_reg      <= cst_pkg::MODE_RST;
            speed_reg     <= cst_pkg::SPEED_RST;
            mtime_reg     <= cst_pkg::MTIME_RST;
            cur_reg       <= '0;
            start_reg     <= '0;
            target_reg    <= '0;
            elapsed_reg   <= '0;
            dur_reg       <= '0;
            busy_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cst_pkg::cfg_idx_t'(cfg_addr))
                    cst_pkg::REG_MIN_ANGLE:    min_angle_reg <= cfg_wdata;
                    cst_pkg::REG_MAX_ANGLE:    max_angle_reg <= cfg_wdata;
                    cst_pkg::REG_OFFSET_ANGLE: offset_reg    <= cfg_wdata[cst_pkg::OFS_W-1:0];
                    cst_pkg::REG_STEP_MS:      step_reg      <= cfg_wdata[cst_pkg::STEP_W-1:0];
                    cst_pkg::REG_MOVE_MODE:    mode_reg      <= cfg_wdata[0];
                    cst_pkg::REG_SPEED_UNITS:  speed_reg     <= cfg_wdata[cst_pkg::SPD_W-1:0];
                    cst_pkg::REG_MOVE_TIME_MS: mtime_reg     <= cfg_wdata[cst_pkg::MTIME_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.set_latch) begin
                target_reg <= {clamp_val[cst_pkg::ANG_W-1], clamp_val};
                start_reg  <= cur_reg;
                dur_reg    <= mode_reg ? cst_pkg::DUR_W'(mtime_reg) : cst_pkg::DUR_MAX;
            end
            if (cmd.dur_load) begin
                dur_reg <= dur_sat;
            end
            if (cmd.tick_eval) begin
                if (sts.move_cond) begin
                    busy_reg    <= 1'b1;
                    elapsed_reg <= elapsed_reg + cst_pkg::ELAP_W'(step_reg);
                end else begin
                    busy_reg    <= 1'b0;
                    cur_reg     <= target_reg;
                    elapsed_reg <= '0;
                end
            end
            if (cmd.ang_load) begin
                cur_reg <= ang_sum[cst_pkg::POS_W-1:0];
            end

            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_target_reg <= s_tdata[cst_pkg::ANG_W-1:0];
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.s_load) begin
            s_reg <= quot[SW-1:0];
        end
        if (cmd.s2_load) begin
            s2_reg <= prod_hi;
        end
        if (cmd.h_load) begin
            h_reg <= h_clamp;
        end
        if (cmd.out_load) begin
            m_data_reg <= {{PAD_W{1'b0}}, start_reg[cst_pkg::ANG_W-1:0], busy_reg, servo_cmd};
        end
    end

    always_comb begin
        sts.need_speed_div = !mode_reg && (speed_reg != '0);
        sts.move_cond      = (elapsed_reg < {1'b0, dur_reg}) && (cur_reg != target_reg);
        sts.div_done       = div_done;
        sts.out_free       = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ hw/rtl/cst_ctrl.sv @@
module cst_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tuser,
    output logic           s_tready,
    input  cst_pkg::sts_t  sts,
    output cst_pkg::cmd_t  cmd
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'h0001,
        ST_SET   = 14'h0002,
        ST_SMUL  = 14'h0004,
        ST_SDIV  = 14'h0008,
        ST_SWAIT = 14'h0010,
        ST_TICK  = 14'h0020,
        ST_TDIV  = 14'h0040,
        ST_TWAIT = 14'h0080,
        ST_SQ    = 14'h0100,
        ST_CUBE  = 14'h0200,
        ST_H     = 14'h0400,
        ST_HMUL  = 14'h0800,
        ST_ANG   = 14'h1000,
        ST_DONE  = 14'h2000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = cst_pkg::MUL_MAG_K;
        cmd.div_sel = cst_pkg::DIV_SPEED;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = (cst_pkg::opcode_t'(s_tuser) == cst_pkg::OP_SET)
                                ? ST_SET : ST_TICK;
                end
            end
            ST_SET: begin
                cmd.set_latch = 1'b1;
                state_next    = sts.need_speed_div ? ST_SMUL : ST_DONE;
            end
            ST_SMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cst_pkg::MUL_MAG_K;
                state_next  = ST_SDIV;
            end
            ST_SDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = cst_pkg::DIV_SPEED;
                state_next    = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (sts.div_done) begin
                    cmd.dur_load = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_TICK: begin
                cmd.tick_eval = 1'b1;
                state_next    = sts.move_cond ? ST_TDIV : ST_DONE;
            end
            ST_TDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = cst_pkg::DIV_TIME;
                state_next    = ST_TWAIT;
            end
            ST_TWAIT: begin
                cmd.div_sel = cst_pkg::DIV_TIME;
                if (sts.div_done) begin
                    cmd.s_load = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cst_pkg::MUL_SS;
                state_next  = ST_CUBE;
            end
            ST_CUBE: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cst_pkg::MUL_S2S;
                cmd.s2_load = 1'b1;
                state_next  = ST_H;
            end
            ST_H: begin
                cmd.h_load = 1'b1;
                state_next = ST_HMUL;
            end
            ST_HMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cst_pkg::MUL_MAGH;
                state_next  = ST_ANG;
            end
            ST_ANG: begin
                cmd.ang_load = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/cubic_servo_trajectory.sv @@
// Cubic servo trajectory generator.
// Input channel s_*: one transaction is one operation. s_tuser is the opcode
// (set target or tick), s_tdata carries the requested target angle.
// Result channel m_*: exactly one result per operation, holding the servo
// command, the busy flag and the start angle of the current move.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write one register per cycle;
// write only while no operation is in flight.
// A set target in fixed mode or at zero speed and a tick that ends a move go
// straight to the result; a set target in speed mode and a tick inside a
// move use the shared bit-serial divider, one quotient bit per cycle.
// A new operation can be accepted in the same cycle that m_tvalid rises.
// Reset (aresetn low, synchronous) restores the register defaults, parks the
// servo at angle zero with no move and empties the result register.
// A stalled receiver holds the result in the output register; the next
// operation is still accepted and worked, then waits until the slot frees.
module cubic_servo_trajectory #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cst_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cst_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cst_pkg::IN_TDATA_W-1:0]    s_tdata,   // target_angle[16:0]
    input  logic                              s_tuser,   // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cst_pkg::OUT_TDATA_W-1:0]   m_tdata    // servo_command[17:0],
                                                          // busy_res[18],
                                                          // start_angle[35:19]
);

    cst_pkg::cmd_t cmd;
    cst_pkg::sts_t sts;

    cst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cst_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    a_result_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result issued without returning to idle");

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten");

    a_div_not_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !sts.div_done)
        else $error("divider finished in one cycle");
`endif

endmodule
